### hw/rtl/gtsc_pkg.sv
// shared types and codes for the grid tie synchronisation check
// used by every module of the block, depends on nothing
package gtsc_pkg;

    typedef enum logic [1:0] {
        MODE_ISLANDED       = 2'd0,
        MODE_GOING_TIED     = 2'd1,
        MODE_TIED           = 2'd2,
        MODE_GOING_ISLANDED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_SAMPLE     = 2'd0,
        CMD_REQ_TIE    = 2'd1,
        CMD_REQ_ISLAND = 2'd2,
        CMD_UNTIE      = 2'd3
    } t_cmd;

    // configuration register indexes
    localparam logic CFG_PHASE_LIMIT   = 1'b0;
    localparam logic CFG_VOLTAGE_LIMIT = 1'b1;

    localparam int ERR_W = 16;

    typedef struct packed {
        logic        islanded_now;
        logic        tied_now;
        t_mode       mode;
    } t_result;

    // one window entry: phase and voltage error side by side
    typedef struct packed {
        logic signed [ERR_W-1:0] voltage;
        logic signed [ERR_W-1:0] phase;
    } t_entry;

endpackage

### hw/rtl/gtsc_cell.sv
// one window cell: holds a phase/voltage error pair and hands it on
// depends on gtsc_pkg
module gtsc_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  gtsc_pkg::t_entry i_entry,
    output gtsc_pkg::t_entry o_entry
);

    gtsc_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### hw/rtl/gtsc_window.sv
// sliding window as a chain of cells, newest enters cell 0
// depends on gtsc_pkg and gtsc_cell
module gtsc_window #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  gtsc_pkg::t_entry i_entry,
    output gtsc_pkg::t_entry o_oldest
);

    gtsc_pkg::t_entry w_link [0:WINDOW_DEPTH];

    assign w_link[0] = i_entry;

    genvar g;
    generate
        for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
            gtsc_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_shift),
                .i_entry (w_link[g]),
                .o_entry (w_link[g+1])
            );
        end
    endgenerate

    // last cell holds the entry pushed WINDOW_DEPTH samples ago
    assign o_oldest = w_link[WINDOW_DEPTH];

endmodule

### hw/rtl/grid_tie_sync_check.sv
// top level of the grid tie synchronisation check: mode controller,
// running sums and output skid; depends on gtsc_pkg and gtsc_window
//
// usage
//   slave channel: one request per command; s_axis_tuser carries the command
//   (sample, request tie, request island, untie step), s_axis_tdata the
//   phase error (bits 15:0) and voltage error (bits 31:16)
//   master channel: one result per request with the mode after it, a tied
//   flag and an islanded flag
//   config port: i_cfg_we writes the phase limit (index 0) or the voltage
//   limit (index 1); the limit is scaled by the window depth as it is stored
// timing
//   a request is worked out in the cycle it is accepted and its result is
//   registered in the output register, or in the skid stage while the master
//   side stalls; one request per cycle is sustained while results are taken
//   the window is a shift chain of cells, so the oldest entry is always at
//   the last cell and needs no memory read
// reset
//   mode islanded, window empty (fill count 0), sums and limits zero; cell
//   contents are not cleared but are never used before they are written
// stall
//   a stalled master side keeps its result; one more result is held in a
//   skid stage, and only then is s_axis_tready dropped
module grid_tie_sync_check #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // phase_err[15:0], volt_err[31:16]
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    // master result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // mode[1:0], tied_now[2], islanded_now[3], zero[7:4]
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    localparam int SUM_W = gtsc_pkg::ERR_W + $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic signed [SUM_W-1:0] DEPTH_S = SUM_W'(WINDOW_DEPTH);

    // scaled limits: limit times window depth
    logic signed [SUM_W-1:0] r_phase_lim;
    logic signed [SUM_W-1:0] r_volt_lim;

    gtsc_pkg::t_mode  r_mode, n_mode;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic signed [SUM_W-1:0] r_phase_sum, n_phase_sum;
    logic signed [SUM_W-1:0] r_volt_sum, n_volt_sum;

    gtsc_pkg::t_result r_out, r_skid, w_res;
    logic r_out_vld, r_skid_vld;

    logic w_accept, w_push, w_full, w_full_next, w_pop;
    gtsc_pkg::t_cmd   w_cmd;
    gtsc_pkg::t_entry w_new, w_oldest;
    logic signed [SUM_W-1:0] w_cfg_ext, w_pe_ext, w_ve_ext, w_po_ext, w_vo_ext;

    assign s_axis_tready = !r_skid_vld;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_cmd         = gtsc_pkg::t_cmd'(s_axis_tuser);
    assign w_new.phase   = s_axis_tdata[15:0];
    assign w_new.voltage = s_axis_tdata[31:16];

    // a sample only counts while going tied
    assign w_push = w_accept && (w_cmd == gtsc_pkg::CMD_SAMPLE)
                    && (r_mode == gtsc_pkg::MODE_GOING_TIED);

    gtsc_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_shift  (w_push),
        .i_entry  (w_new),
        .o_oldest (w_oldest)
    );

    // config: scale the limit once as it is written
    assign w_cfg_ext = {{(SUM_W-16){i_cfg_data[15]}}, i_cfg_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_lim <= '0;
            r_volt_lim  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == gtsc_pkg::CFG_PHASE_LIMIT) begin
                r_phase_lim <= SUM_W'(w_cfg_ext * DEPTH_S);
            end else begin
                r_volt_lim  <= SUM_W'(w_cfg_ext * DEPTH_S);
            end
        end
    end

    // window fill and running sums
    assign w_full   = (r_fill == DEPTH_CNT);
    assign w_pe_ext = {{(SUM_W-16){w_new.phase[15]}}, w_new.phase};
    assign w_ve_ext = {{(SUM_W-16){w_new.voltage[15]}}, w_new.voltage};
    // oldest entry leaves the sum only once the window is full
    assign w_po_ext = w_full ? {{(SUM_W-16){w_oldest.phase[15]}}, w_oldest.phase} : '0;
    assign w_vo_ext = w_full ? {{(SUM_W-16){w_oldest.voltage[15]}}, w_oldest.voltage} : '0;

    always_comb begin
        n_fill      = r_fill;
        n_phase_sum = r_phase_sum;
        n_volt_sum  = r_volt_sum;
        if (w_push) begin
            if (!w_full) begin
                n_fill = r_fill + CNT_W'(1);
            end
            n_phase_sum = r_phase_sum + w_pe_ext - w_po_ext;
            n_volt_sum  = r_volt_sum + w_ve_ext - w_vo_ext;
        end
    end

    assign w_full_next = (n_fill == DEPTH_CNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_phase_sum <= '0;
            r_volt_sum  <= '0;
        end else begin
            r_fill      <= n_fill;
            r_phase_sum <= n_phase_sum;
            r_volt_sum  <= n_volt_sum;
        end
    end

    // mode state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= gtsc_pkg::MODE_ISLANDED;
        end else begin
            r_mode <= n_mode;
        end
    end

    always_comb begin
        n_mode             = r_mode;
        w_res.tied_now     = 1'b0;
        w_res.islanded_now = 1'b0;
        if (w_accept) begin
            unique case (r_mode)
                gtsc_pkg::MODE_ISLANDED: begin
                    if (w_cmd == gtsc_pkg::CMD_REQ_TIE) begin
                        n_mode = gtsc_pkg::MODE_GOING_TIED;
                    end
                end
                gtsc_pkg::MODE_GOING_TIED: begin
                    // tie once full and both averages sit below their limits
                    if (w_push && w_full_next && (n_phase_sum < r_phase_lim)
                        && (n_volt_sum < r_volt_lim)) begin
                        n_mode         = gtsc_pkg::MODE_TIED;
                        w_res.tied_now = 1'b1;
                    end
                end
                gtsc_pkg::MODE_TIED: begin
                    if (w_cmd == gtsc_pkg::CMD_REQ_ISLAND) begin
                        n_mode = gtsc_pkg::MODE_GOING_ISLANDED;
                    end
                end
                gtsc_pkg::MODE_GOING_ISLANDED: begin
                    if (w_cmd == gtsc_pkg::CMD_UNTIE) begin
                        n_mode             = gtsc_pkg::MODE_ISLANDED;
                        w_res.islanded_now = 1'b1;
                    end
                end
            endcase
        end
        w_res.mode = n_mode;
    end

    // output register plus skid stage
    assign w_pop = r_out_vld && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || w_pop) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || w_pop) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_res;
            end
        end else if (w_accept) begin
            r_skid <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {4'b0000, r_out.islanded_now, r_out.tied_now, r_out.mode};

    // a held skid result always has an older result ahead of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid stage full with empty output register");

    // fill count never passes the window depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= DEPTH_CNT)
        else $error("window fill count beyond depth");

    // a tie only happens on a window that was full after the sample
    a_tie_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_res.tied_now) |=> (r_fill == DEPTH_CNT)
            && (r_mode == gtsc_pkg::MODE_TIED))
        else $error("tie without a full window");

    // a result that reports a tie carries the tied mode
    a_tied_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.tied_now) |-> (r_out.mode == gtsc_pkg::MODE_TIED))
        else $error("tied flag with wrong mode");

    // the window only moves while going tied
    a_push_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> ($past(r_mode) == gtsc_pkg::MODE_GOING_TIED))
        else $error("window filled outside going tied");

endmodule

### dv/testbench.sv
// self-checking testbench for grid_tie_sync_check: stream requests in, mode results out
// keeps its own model of the mode controller and sliding windows in a scoreboard class
// depends on gtsc_pkg and the grid_tie_sync_check top level
`timescale 1ns / 1ps

module testbench;

    localparam int WINDOW_DEPTH = 256;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int NUM_PHASES   = 8;
    // requests that really move the block (ignored commands do not count)
    localparam int ACTIVE_PER_PHASE = 200;

    // ------------------------------------------------------------------
    // scoreboard: tracks mode, windows and running sums, and holds the
    // results still owed by the block in arrival order
    // ------------------------------------------------------------------
    class t_tie_tracker;
        gtsc_pkg::t_mode                   mode_now;
        logic signed [gtsc_pkg::ERR_W-1:0] phase_hist [WINDOW_DEPTH];
        logic signed [gtsc_pkg::ERR_W-1:0] volt_hist [WINDOW_DEPTH];
        int                                slot;
        int                                filled;
        longint                            phase_total;
        longint                            volt_total;
        logic signed [gtsc_pkg::ERR_W-1:0] phase_limit;
        logic signed [gtsc_pkg::ERR_W-1:0] volt_limit;
        gtsc_pkg::t_result                 owed_results[$];
        int                                mismatches;

        function new();
            mode_now    = gtsc_pkg::MODE_ISLANDED;
            slot        = 0;
            filled      = 0;
            phase_total = 0;
            volt_total  = 0;
            phase_limit = '0;
            volt_limit  = '0;
            mismatches  = 0;
        endfunction

        task report_mismatch(input string what);
            $display("mismatch at %0t ns: %s", $realtime, what);
            mismatches++;
        endtask

        function void set_limit(input logic addr, input logic [15:0] value);
            if (addr == gtsc_pkg::CFG_PHASE_LIMIT)
                phase_limit = value;
            else
                volt_limit = value;
        endfunction

        // works out the result of one accepted request; returns 1 when the
        // request did something (as opposed to being ignored in this mode)
        function bit note_request(input gtsc_pkg::t_cmd cmd,
                                  input logic signed [gtsc_pkg::ERR_W-1:0] pe,
                                  input logic signed [gtsc_pkg::ERR_W-1:0] ve);
            gtsc_pkg::t_result r;
            bit                acted;
            r.tied_now     = 1'b0;
            r.islanded_now = 1'b0;
            acted          = 1'b0;
            case (cmd)
                gtsc_pkg::CMD_SAMPLE: begin
                    if (mode_now == gtsc_pkg::MODE_GOING_TIED) begin
                        acted = 1'b1;
                        // full window: oldest entry drops out of the sums
                        if (filled >= WINDOW_DEPTH) begin
                            phase_total -= phase_hist[slot];
                            volt_total  -= volt_hist[slot];
                        end else begin
                            filled++;
                        end
                        phase_hist[slot] = pe;
                        volt_hist[slot]  = ve;
                        phase_total += pe;
                        volt_total  += ve;
                        slot = (slot + 1) % WINDOW_DEPTH;
                        if (filled >= WINDOW_DEPTH
                            && phase_total < longint'(phase_limit) * WINDOW_DEPTH
                            && volt_total < longint'(volt_limit) * WINDOW_DEPTH) begin
                            mode_now   = gtsc_pkg::MODE_TIED;
                            r.tied_now = 1'b1;
                        end
                    end
                end
                gtsc_pkg::CMD_REQ_TIE: begin
                    if (mode_now == gtsc_pkg::MODE_ISLANDED) begin
                        mode_now = gtsc_pkg::MODE_GOING_TIED;
                        acted    = 1'b1;
                    end
                end
                gtsc_pkg::CMD_REQ_ISLAND: begin
                    if (mode_now == gtsc_pkg::MODE_TIED) begin
                        mode_now = gtsc_pkg::MODE_GOING_ISLANDED;
                        acted    = 1'b1;
                    end
                end
                default: begin
                    if (mode_now == gtsc_pkg::MODE_GOING_ISLANDED) begin
                        mode_now       = gtsc_pkg::MODE_ISLANDED;
                        r.islanded_now = 1'b1;
                        acted          = 1'b1;
                    end
                end
            endcase
            r.mode = mode_now;
            owed_results.push_back(r);
            return acted;
        endfunction

        task check_result(input logic [7:0] data);
            gtsc_pkg::t_result want;
            gtsc_pkg::t_result got;
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("result 0x%02h with nothing owed", data));
                return;
            end
            want = owed_results.pop_front();
            got  = gtsc_pkg::t_result'(data[3:0]);
            if (got.mode !== want.mode)
                report_mismatch($sformatf("mode %0d, expected %0d", got.mode, want.mode));
            if (got.tied_now !== want.tied_now)
                report_mismatch($sformatf("tied_now %0b, expected %0b",
                                          got.tied_now, want.tied_now));
            if (got.islanded_now !== want.islanded_now)
                report_mismatch($sformatf("islanded_now %0b, expected %0b",
                                          got.islanded_now, want.islanded_now));
            if (data[7:4] !== 4'b0000)
                report_mismatch($sformatf("pad bits 0x%01h, expected zero", data[7:4]));
        endtask
    endclass

    // ------------------------------------------------------------------
    // block and its ports, every input known from time zero
    // ------------------------------------------------------------------
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata   = '0;  // phase_err[15:0], volt_err[31:16]
    logic [1:0]  s_axis_tuser   = '0;  // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [7:0]  m_axis_tdata;         // mode[1:0], tied_now[2], islanded_now[3], zero[7:4]
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_addr     = 1'b0;
    logic [15:0] i_cfg_data     = '0;

    t_tie_tracker tracker = new();

    // idle bursts: while set, that side never waits
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;
    int unsigned stall_left = 0;

    grid_tie_sync_check #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL grid_tie_sync_check");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stall after every result, with stall-free
    // stretches; each accepted result is checked at once
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            tracker.check_result(m_axis_tdata);
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            stall_left = recv_burst ? 0 : $urandom_range(0, 12);
            m_axis_tready <= (stall_left == 0);
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= (stall_left == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one request: random gap, then hold it until accepted; valid is only
    // lowered when a gap follows, so back-to-back requests keep it high
    task automatic send_request(input gtsc_pkg::t_cmd cmd, input logic [15:0] pe,
                                input logic [15:0] ve, output bit acted);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {ve, pe};
        do @(posedge i_clk); while (!s_axis_tready);
        acted = tracker.note_request(cmd, pe, ve);
    endtask

    // wait until every owed result has come back, with valid already low
    task automatic drain_results();
        while (tracker.owed_results.size() != 0)
            @(posedge i_clk);
    endtask

    // both limits, back to back, while the block is idle
    task automatic write_limits(input logic [15:0] phase_lim, input logic [15:0] volt_lim);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= gtsc_pkg::CFG_PHASE_LIMIT;
        i_cfg_data <= phase_lim;
        @(posedge i_clk);
        tracker.set_limit(gtsc_pkg::CFG_PHASE_LIMIT, phase_lim);
        i_cfg_addr <= gtsc_pkg::CFG_VOLTAGE_LIMIT;
        i_cfg_data <= volt_lim;
        @(posedge i_clk);
        tracker.set_limit(gtsc_pkg::CFG_VOLTAGE_LIMIT, volt_lim);
        i_cfg_we <= 1'b0;
    endtask

    // error sample: mostly clustered round a bias so averages land near the
    // limits, sometimes any 16-bit value
    function automatic logic [15:0] draw_error(input int bias);
        int v;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        v = bias + int'($urandom_range(0, 1023)) - 512;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int             phase_lim [NUM_PHASES];
        int             volt_lim [NUM_PHASES];
        int             phase_bias [NUM_PHASES];
        int             volt_bias [NUM_PHASES];
        int             active;
        bit             acted;
        gtsc_pkg::t_cmd cmd;
        logic [15:0]    pe;
        logic [15:0]    ve;

        // limit settings per phase: reset values first, then the extremes
        // (never ties, always ties) mixed with limits near the sample spread
        phase_lim  = '{0, 32767, -32768, 150, -32768, 32767, -120, 32767};
        volt_lim   = '{0, 32767, 32767, -90, -32768, -32768, 200, 32767};
        phase_bias = '{0, 32767, 0, 100, 0, 0, -200, -32768};
        volt_bias  = '{0, 32700, 0, -150, 0, 0, 300, 32767};
        phase_lim[3] = int'($urandom_range(0, 600)) - 300;
        volt_lim[3]  = int'($urandom_range(0, 600)) - 300;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every command in islanded and going tied, field extremes
        // ignored when islanded
        send_request(gtsc_pkg::CMD_UNTIE, 16'h0000, 16'h0000, acted);
        send_request(gtsc_pkg::CMD_REQ_ISLAND, 16'hFFFF, 16'hFFFF, acted);
        // sample dropped, no window
        send_request(gtsc_pkg::CMD_SAMPLE, 16'h7FFF, 16'h8000, acted);
        send_request(gtsc_pkg::CMD_REQ_TIE, 16'h0000, 16'h0000, acted);
        // ignored, already going
        send_request(gtsc_pkg::CMD_REQ_TIE, 16'h1234, 16'h4321, acted);
        // ignored, not tied
        send_request(gtsc_pkg::CMD_REQ_ISLAND, 16'h0000, 16'h0000, acted);
        // ignored, not going islanded
        send_request(gtsc_pkg::CMD_UNTIE, 16'h0000, 16'h0000, acted);
        send_request(gtsc_pkg::CMD_SAMPLE, 16'h7FFF, 16'h8000, acted);
        send_request(gtsc_pkg::CMD_SAMPLE, 16'h8000, 16'h7FFF, acted);
        send_request(gtsc_pkg::CMD_SAMPLE, 16'h0000, 16'h0000, acted);
        send_request(gtsc_pkg::CMD_SAMPLE, 16'hFFFF, 16'hFFFF, acted);
        send_request(gtsc_pkg::CMD_SAMPLE, 16'h0001, 16'hFFFE, acted);
        send_request(gtsc_pkg::CMD_SAMPLE, 16'h5555, 16'hAAAA, acted);
        send_request(gtsc_pkg::CMD_SAMPLE, 16'hAAAA, 16'h5555, acted);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // registers change only with nothing in flight
            s_axis_tvalid <= 1'b0;
            drain_results();
            if (ph != 0)
                write_limits(16'(phase_lim[ph]), 16'(volt_lim[ph]));

            active = 0;
            while (active < ACTIVE_PER_PHASE) begin
                pe = draw_error(phase_bias[ph]);
                ve = draw_error(volt_bias[ph]);
                if ($urandom_range(0, 99) < 15) begin
                    // noise: any command, any data, whatever the mode
                    cmd = gtsc_pkg::t_cmd'($urandom_range(0, 3));
                    pe  = 16'($urandom);
                    ve  = 16'($urandom);
                end else begin
                    // well-formed tie / untie cycle driven by the predicted mode
                    case (tracker.mode_now)
                        gtsc_pkg::MODE_ISLANDED:   cmd = gtsc_pkg::CMD_REQ_TIE;
                        gtsc_pkg::MODE_GOING_TIED: cmd = gtsc_pkg::CMD_SAMPLE;
                        gtsc_pkg::MODE_TIED:
                            cmd = ($urandom_range(0, 3) != 0) ? gtsc_pkg::CMD_REQ_ISLAND
                                                              : gtsc_pkg::CMD_SAMPLE;
                        default:                   cmd = gtsc_pkg::CMD_UNTIE;
                    endcase
                end
                send_request(cmd, pe, ve, acted);
                if (acted)
                    active++;
            end
        end

        s_axis_tvalid <= 1'b0;
        drain_results();
        // result path is the output register plus a skid stage deep
        repeat (8) @(posedge i_clk);
        if (tracker.owed_results.size() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.owed_results.size()));

        if (tracker.mismatches == 0)
            $display("PASS grid_tie_sync_check");
        else
            $display("FAIL grid_tie_sync_check");
        $finish;
    end

endmodule
